### rtl/imu_rx_pkg.sv
// Shared constants, types and the CRC-16 CCITT byte update for the IMU packet receiver.
// Used by every module under rtl/. No dependencies.
`timescale 1ns / 1ps

package imu_rx_pkg;

    // Packet geometry: bytes after the sync byte are numbered from 0
    localparam int unsigned PKT_LAST    = 40;  // low CRC byte, ends the packet
    localparam int unsigned CRC_SPAN    = 39;  // bytes 0..38 enter the CRC; byte 39 is CRC high
    localparam int unsigned FIELD_FIRST = 3;   // first payload byte
    localparam int unsigned FIELD_COUNT = 9;   // 32-bit words in the payload
    localparam int unsigned STORE_BITS  = FIELD_COUNT * 32;
    localparam int unsigned IDX_W       = 6;

    localparam logic [7:0]       SYNC_RESET = 8'hFA;
    localparam logic [IDX_W-1:0] IDX_FIRST  = IDX_W'(FIELD_FIRST);
    localparam logic [IDX_W-1:0] IDX_CRC_HI = IDX_W'(CRC_SPAN);
    localparam logic [IDX_W-1:0] IDX_LAST   = IDX_W'(PKT_LAST);

    typedef logic [31:0] t_word;

    // Event from the framer for the byte taken this cycle
    typedef struct packed {
        logic fire;    // this byte ends a packet
        logic crc_ok;  // received CRC matched the running CRC
    } t_frame_evt;

    // Byte-wise CRC-16 CCITT update (polynomial 0x1021, no reflection)
    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        begin
            c = {crc[7:0], crc[15:8]};
            c = c ^ {8'h00, b};
            c = c ^ {12'h000, c[7:4]};
            c = c ^ {c[3:0], 12'h000};
            c = c ^ {3'b000, c[7:0], 5'b00000};
            return c;
        end
    endfunction

endpackage

### rtl/imu_binary_packet_receiver.sv
// IMU binary packet receiver: takes one byte per cycle, emits one result per packet.
// The result becomes valid in the cycle after the last packet byte is taken.
// Throughput: one byte per cycle; a byte is stalled only when it would end a packet
// while the previous result is still waiting to be taken.
// Reset (synchronous, active low): hunting for sync, sync value 0xFA, held words zero.
// Depends on imu_rx_pkg, imu_rx_frame, imu_rx_out.
`timescale 1ns / 1ps

module imu_binary_packet_receiver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_data,
    // input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    // output channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_crc_ok,
    output logic [31:0] o_yaw_bits,
    output logic [31:0] o_pitch_bits,
    output logic [31:0] o_roll_bits,
    output logic [31:0] o_rate_x_bits,
    output logic [31:0] o_rate_y_bits,
    output logic [31:0] o_rate_z_bits,
    output logic [31:0] o_accel_x_bits,
    output logic [31:0] o_accel_y_bits,
    output logic [31:0] o_accel_z_bits
);
    import imu_rx_pkg::*;

    logic [7:0]            r_sync;
    logic                  take;
    logic                  at_last;
    t_frame_evt            evt;
    logic [STORE_BITS-1:0] store;
    t_word                 held [FIELD_COUNT];

    // Sync byte register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync <= SYNC_RESET;
        end else if (i_cfg_we) begin
            r_sync <= i_cfg_data;
        end
    end

    // Hold the packet-ending byte while a result still waits
    assign o_stall = at_last && o_valid && i_stall;
    assign take    = i_valid && !o_stall;

    imu_rx_frame u_frame (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_sync_value (r_sync),
        .i_take       (take),
        .i_rx_byte    (i_rx_byte),
        .o_at_last    (at_last),
        .o_evt        (evt),
        .o_store      (store)
    );

    imu_rx_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_evt    (evt),
        .i_store  (store),
        .i_stall  (i_stall),
        .o_valid  (o_valid),
        .o_crc_ok (o_crc_ok),
        .o_held   (held)
    );

    assign o_yaw_bits     = held[0];
    assign o_pitch_bits   = held[1];
    assign o_roll_bits    = held[2];
    assign o_rate_x_bits  = held[3];
    assign o_rate_y_bits  = held[4];
    assign o_rate_z_bits  = held[5];
    assign o_accel_x_bits = held[6];
    assign o_accel_y_bits = held[7];
    assign o_accel_z_bits = held[8];

endmodule

### rtl/imu_rx_frame.sv
// Packet framer: sync hunt, byte counter, running CRC and payload shift line.
// Depends on imu_rx_pkg.
`timescale 1ns / 1ps

module imu_rx_frame (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [7:0]                          i_sync_value,
    input  logic                                i_take,
    input  logic [7:0]                          i_rx_byte,
    output logic                                o_at_last,
    output imu_rx_pkg::t_frame_evt              o_evt,
    output logic [imu_rx_pkg::STORE_BITS-1:0]   o_store
);
    import imu_rx_pkg::*;

    logic                   r_hunting, n_hunting;
    logic [IDX_W-1:0]       r_idx, n_idx;
    logic [15:0]            r_crc, n_crc;
    logic [7:0]             r_crc_hi;
    logic [STORE_BITS-1:0]  r_store;
    logic                   in_crc_span;
    logic                   in_fields;

    assign in_crc_span = (r_idx < IDX_CRC_HI);
    assign in_fields   = (r_idx >= IDX_FIRST) && in_crc_span;
    assign o_at_last   = !r_hunting && (r_idx == IDX_LAST);
    assign o_store     = r_store;

    // Advance hunt / count / CRC for the item taken this cycle
    always_comb begin
        n_hunting    = r_hunting;
        n_idx        = r_idx;
        n_crc        = r_crc;
        o_evt.fire   = 1'b0;
        o_evt.crc_ok = (r_crc == {r_crc_hi, i_rx_byte});
        if (i_take) begin
            if (r_hunting) begin
                if (i_rx_byte == i_sync_value) begin
                    n_hunting = 1'b0;
                    n_idx     = '0;
                    n_crc     = '0;
                end
            end else if (in_crc_span) begin
                n_crc = crc_step(r_crc, i_rx_byte);
                n_idx = r_idx + IDX_W'(1);
            end else if (r_idx == IDX_CRC_HI) begin
                n_idx = r_idx + IDX_W'(1);
            end else begin
                o_evt.fire = 1'b1;
                n_hunting  = 1'b1;
                n_idx      = '0;
                n_crc      = '0;
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hunting <= 1'b1;
            r_idx     <= '0;
            r_crc     <= '0;
        end else begin
            r_hunting <= n_hunting;
            r_idx     <= n_idx;
            r_crc     <= n_crc;
        end
    end

    // Payload: shift bytes in from the top so byte 3 ends at the bottom
    always_ff @(posedge i_clk) begin
        if (i_take && !r_hunting && in_fields) begin
            r_store <= {i_rx_byte, r_store[STORE_BITS-1:8]};
        end
        if (i_take && !r_hunting && (r_idx == IDX_CRC_HI)) begin
            r_crc_hi <= i_rx_byte;
        end
    end

endmodule

### rtl/imu_rx_out.sv
// Result register: held IMU words and crc_ok flag, with valid/stall output handshake.
// Depends on imu_rx_pkg.
`timescale 1ns / 1ps

module imu_rx_out (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  imu_rx_pkg::t_frame_evt              i_evt,
    input  logic [imu_rx_pkg::STORE_BITS-1:0]   i_store,
    input  logic                                i_stall,
    output logic                                o_valid,
    output logic                                o_crc_ok,
    output imu_rx_pkg::t_word                   o_held [imu_rx_pkg::FIELD_COUNT]
);
    import imu_rx_pkg::*;

    logic  r_valid;
    logic  r_crc_ok;
    t_word r_held [FIELD_COUNT];

    assign o_valid  = r_valid;
    assign o_crc_ok = r_crc_ok;
    assign o_held   = r_held;

    // Load a result at packet end, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_evt.fire) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_evt.fire) begin
            r_crc_ok <= i_evt.crc_ok;
        end
    end

    // Held words update only on a good CRC
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < FIELD_COUNT; k++) begin
                r_held[k] <= '0;
            end
        end else if (i_evt.fire && i_evt.crc_ok) begin
            for (int k = 0; k < FIELD_COUNT; k++) begin
                r_held[k] <= i_store[k*32 +: 32];
            end
        end
    end

endmodule
